>>> hw/rtl/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
`default_nettype none

package bba_pkg;

  // Fixed field widths of the ports
  localparam int CFG_W = 13;   // configuration register width
  localparam int BLK_W = 12;   // block number width on the ports

  // Defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] FIRST_DATA_BLOCK_RST = 13'd0;
  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST      = 13'd4096;

  typedef enum logic [0:0] {
    REG_FIRST_DATA_BLOCK = 1'b0,
    REG_BLOCK_COUNT      = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_OUT_OF_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FCHK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/block_bitmap_allocator_top.sv
// First-fit block bitmap allocator with the used bitmap held in one synchronous RAM.
// Flow: an immediate answer (out of range, empty scan window) goes from accept straight to
//   the result state, a free first checks its word, an allocate first scans bitmap words.
// Throughput: one item at a time; the scan reads one RAM word per cycle.
// Reset: synchronous, active low; a clearing pass then zeroes one RAM word per cycle
//   over all ceil(NUM_BLOCKS/WORD_BITS) words (128 at the defaults) with in_ready low.
`default_nettype none

module block_bitmap_allocator_top
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,  // 32 .. 4096
  parameter int WORD_BITS  = WORD_BITS_DEF    // power of two, 8 .. 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_action,
  input  wire logic [BLK_W-1:0] in_block_number,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output logic [BLK_W-1:0]      out_allocated_block,
  // configuration writes
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // Bitmap geometry: bit b of word w is block w*WORD_BITS+b
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LB        = $clog2(WORD_BITS);
  // Largest usable limit: block_count is capped at NUM_BLOCKS
  localparam int CAP_INT   = (NUM_BLOCKS > (2 ** CFG_W) - 1) ? (2 ** CFG_W) - 1 : NUM_BLOCKS;
  localparam logic [CFG_W-1:0] LIM_CAP   = CFG_W'(CAP_INT);
  localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);

  typedef logic [WORD_BITS-1:0] word_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r;          // clearing pass pointer
  logic [AW-1:0]      cur_w_r, cur_w_nxt;  // word under test
  logic               first_r, first_nxt;  // first word of a scan: mask low bits
  logic [LB-1:0]      bit_r, bit_nxt;      // bit to free
  status_t            res_status_r, res_status_nxt;
  logic [BLK_W-1:0]   res_block_r, res_block_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [BLK_W-1:0]   out_block_r, out_block_nxt;
  logic [CFG_W-1:0]   cfg_first_r;
  logic [CFG_W-1:0]   cfg_count_r;

  // Bitmap RAM: one write port, one registered read port
  word_t              used_mem [MAP_WORDS];
  word_t              mem_q_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  word_t              mem_wd;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;

  // ---------------------------------------------------------------------------
  // Scan window and word search
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   lim;
  logic [CFG_W-1:0]   start_blk;
  logic               alloc_empty;    // scan window is empty
  logic               free_oor;       // free request beyond the limit
  logic [31:0]        base;           // first block of the current word
  logic [31:0]        rem;            // blocks left below the limit from base
  logic               last_word;
  logic [LB-1:0]      lo_bit;
  word_t              allowed;
  word_t              free_vec;
  logic               found;
  logic [LB-1:0]      found_bit;
  logic [31:0]        found_blk;

  assign lim         = (cfg_count_r > LIM_CAP) ? LIM_CAP : cfg_count_r;
  assign start_blk   = cfg_first_r;
  assign alloc_empty = (start_blk >= lim);
  assign free_oor    = ({1'b0, in_block_number} >= lim);

  assign base      = 32'(cur_w_r) << LB;
  assign rem       = 32'(lim) - base;
  assign last_word = ((32'(cur_w_r) + 32'd1) << LB) >= 32'(lim);
  assign lo_bit    = first_r ? start_blk[LB-1:0] : '0;

  // Keep only bits inside [start, lim) of this word
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      allowed[b] = (LB'(b) >= lo_bit) && (32'(b) < rem);
    end
  end

  assign free_vec = ~mem_q_r & allowed;

  // Lowest clear bit wins
  always_comb begin
    found     = 1'b0;
    found_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        found     = 1'b1;
        found_bit = LB'(b);
      end
    end
  end

  assign found_blk = base + 32'(found_bit);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_WORD) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (action_t'(in_action) == ACT_ALLOC) begin
            state_nxt = alloc_empty ? S_DONE : S_SCAN;
          end else begin
            state_nxt = free_oor ? S_DONE : S_FCHK;
          end
        end
      end
      S_SCAN: begin
        if (found || last_word) state_nxt = S_DONE;
      end
      S_FCHK: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and RAM control
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready       = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = cur_w_r;
    mem_wd         = mem_q_r;
    rd_en          = 1'b0;
    rd_addr        = cur_w_r;
    cur_w_nxt      = cur_w_r;
    first_nxt      = first_r;
    bit_nxt        = bit_r;
    res_status_nxt = res_status_r;
    res_block_nxt  = res_block_r;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    // drop the result once taken
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        mem_wd = '0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_block_nxt = '0;
          if (action_t'(in_action) == ACT_ALLOC) begin
            res_status_nxt = ST_NO_FREE;
            cur_w_nxt      = AW'(start_blk >> LB);
            first_nxt      = 1'b1;
            rd_en          = !alloc_empty;
            rd_addr        = AW'(start_blk >> LB);
          end else if (free_oor) begin
            res_status_nxt = ST_OUT_OF_RANGE;
          end else begin
            cur_w_nxt = AW'(in_block_number >> LB);
            bit_nxt   = in_block_number[LB-1:0];
            rd_en     = 1'b1;
            rd_addr   = AW'(in_block_number >> LB);
          end
        end
      end
      S_SCAN: begin
        first_nxt = 1'b0;
        // fetch the following word ahead; it is used only if this one has no hit
        if (!last_word) begin
          rd_en     = 1'b1;
          rd_addr   = cur_w_r + AW'(1);
          cur_w_nxt = cur_w_r + AW'(1);
        end
        if (found) begin
          mem_we         = 1'b1;
          mem_wd         = mem_q_r | (WORD_BITS'(1) << found_bit);
          res_status_nxt = ST_OK;
          res_block_nxt  = BLK_W'(found_blk);
        end
      end
      S_FCHK: begin
        if (mem_q_r[bit_r]) begin
          mem_we         = 1'b1;
          mem_wd         = mem_q_r & ~(WORD_BITS'(1) << bit_r);
          res_status_nxt = ST_OK;
        end else begin
          res_status_nxt = ST_ALREADY_FREE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_block_nxt  = res_block_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequential logic
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      cfg_first_r <= FIRST_DATA_BLOCK_RST;
      cfg_count_r <= BLOCK_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_FIRST_DATA_BLOCK: cfg_first_r <= cfg_data;
          REG_BLOCK_COUNT:      cfg_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    cur_w_r      <= cur_w_nxt;
    first_r      <= first_nxt;
    bit_r        <= bit_nxt;
    res_status_r <= res_status_nxt;
    res_block_r  <= res_block_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
  end

  // Bitmap RAM; a write and a read in the same cycle never hit the same word
  always_ff @(posedge clk) begin
    if (mem_we) used_mem[mem_wa] <= mem_wd;
    if (rd_en)  mem_q_r <= used_mem[rd_addr];
  end

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_allocated_block = out_block_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

  a_hit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found) |-> (found_blk < 32'(lim) && found_blk >= 32'(start_blk)))
    else $error("allocated block outside scan window");

  a_hit_reports_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && found) |=> (state_r == S_DONE && res_status_r == ST_OK))
    else $error("allocation hit not reported as ok");

  a_free_clears_set_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FCHK && mem_we) |-> mem_q_r[bit_r])
    else $error("free wrote back a word whose bit was clear");

  a_read_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && state_r == S_SCAN) |-> (32'(rd_addr) < MAP_WORDS))
    else $error("scan read beyond bitmap depth");

  a_wait_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("pending result dropped while output slot busy");

endmodule

`default_nettype wire

>>> bench/block_bitmap_allocator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the first-fit block bitmap allocator: scripted and random requests.
module block_bitmap_allocator_top_tb;
  import bba_pkg::*;

  localparam int MAP_BLOCKS  = NUM_BLOCKS_DEF;
  localparam int RANDOM_REQS = 1950;
  // Longest legal quiet stretch is the clearing pass or a full scan plus a stall; allow many.
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] block;
  } alloc_result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    action_t          act;
    logic [BLK_W-1:0] blk;
    reg_idx_t         idx;
    logic [CFG_W-1:0] data;
    bit               typed;
    alloc_result_t    res;
  } script_row_t;

  // Drive every input to a known value from time zero.
  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_ready;
  logic             in_action       = 1'b0;
  logic [BLK_W-1:0] in_block_number = '0;
  logic             out_valid;
  logic             out_ready       = 1'b0;
  logic [1:0]       out_status;
  logic [BLK_W-1:0] out_allocated_block;
  logic             cfg_valid       = 1'b0;
  logic             cfg_ready;
  logic             cfg_index       = 1'b0;
  logic [CFG_W-1:0] cfg_data        = '0;

  // Typed-in expectation that travels with the item currently on the input channel.
  bit               req_typed       = 1'b0;
  alloc_result_t    req_result      = '0;

  // Shadow of the allocator: used bits and the two registers.
  bit               used_map [MAP_BLOCKS];
  logic [CFG_W-1:0] first_block_q   = FIRST_DATA_BLOCK_RST;
  logic [CFG_W-1:0] block_count_q   = BLOCK_COUNT_RST;

  alloc_result_t    pending_results [$];
  script_row_t      script [$];
  int               fail_count      = 0;
  int               quiet_cycles    = 0;
  int               rdy_left        = 0;

  block_bitmap_allocator_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_allocated_block (out_allocated_block),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Serve one request against the shadow bitmap and return what the block must answer.
  function automatic alloc_result_t serve_request(action_t act, logic [BLK_W-1:0] blk);
    int            lim;
    int            i;
    alloc_result_t res;
    // Clamp the block count to the storage that exists.
    lim = (block_count_q > MAP_BLOCKS) ? MAP_BLOCKS : int'(block_count_q);
    res.status = ST_NO_FREE;
    res.block  = '0;
    if (act == ACT_ALLOC) begin
      // First fit: take the lowest clear bit in [first block, limit).
      for (i = int'(first_block_q); i < lim; i++) begin
        if (!used_map[i]) begin
          used_map[i] = 1'b1;
          res.status  = ST_OK;
          res.block   = i[BLK_W-1:0];
          break;
        end
      end
    end else if (int'(blk) >= lim) begin
      res.status = ST_OUT_OF_RANGE;
    end else if (used_map[blk]) begin
      used_map[blk] = 1'b0;
      res.status    = ST_OK;
    end else begin
      res.status = ST_ALREADY_FREE;
    end
    return res;
  endfunction

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    alloc_result_t pred;
    if (rst_n) begin
      // Check the result first: it belongs to an older item than any accepted now.
      if (out_valid && out_ready) begin
        got.status = status_t'(out_status);
        got.block  = out_allocated_block;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] unexpected result: status %0d block %0d",
                     $realtime, got.status, got.block);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("[%0t] mismatch: status exp %0d got %0d, block exp %0d got %0d",
                       $realtime, want.status, got.status, want.block, got.block);
          end
        end
      end
      // Track register writes in the shadow copy.
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_FIRST_DATA_BLOCK: first_block_q = cfg_data;
          REG_BLOCK_COUNT:      block_count_q = cfg_data;
          default: ;
        endcase
      end
      // Advance the shadow for every accepted item; prefer the typed-in answer where given.
      if (in_valid && in_ready) begin
        pred = serve_request(action_t'(in_action), in_block_number);
        pending_results.push_back(req_typed ? req_result : pred);
      end
    end
  end

  // Abort when nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: mix long ready stretches, long stalls and cycle-by-cycle chatter.
  always @(negedge clk) begin
    int pick;
    if (rdy_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        out_ready <= 1'b1;
        rdy_left  <= $urandom_range(1, 60);
      end else if (pick < 7) begin
        out_ready <= 1'b0;
        rdy_left  <= $urandom_range(1, 25);
      end else begin
        out_ready <= 1'($urandom_range(0, 1));
        rdy_left  <= 1;
      end
    end else begin
      rdy_left <= rdy_left - 1;
    end
  end

  function automatic void add_req(action_t act, logic [BLK_W-1:0] blk, bit typed,
                                  status_t st, logic [BLK_W-1:0] ab);
    script_row_t row;
    row.kind       = ROW_REQ;
    row.act        = act;
    row.blk        = blk;
    row.idx        = REG_FIRST_DATA_BLOCK;
    row.data       = '0;
    row.typed      = typed;
    row.res.status = st;
    row.res.block  = ab;
    script.push_back(row);
  endfunction

  function automatic void add_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    script_row_t row;
    row.kind  = ROW_REG;
    row.act   = ACT_ALLOC;
    row.blk   = '0;
    row.idx   = idx;
    row.data  = data;
    row.typed = 1'b0;
    row.res   = '0;
    script.push_back(row);
  endfunction

  // Present one item at the falling edge and hold it until accepted.
  task automatic send_request(action_t act, logic [BLK_W-1:0] blk, bit typed,
                              alloc_result_t res);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_action       <= act;
    in_block_number <= blk;
    req_typed       <= typed;
    req_result      <= res;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Drop valid and wait until every outstanding item has answered.
  task automatic wait_drained();
    hold_off(1);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick a register setting: mostly small windows anywhere in the map, sometimes an extreme.
  task automatic choose_window(output int fdb, output int cnt);
    int pick;
    int base;
    int size;
    pick = $urandom_range(0, 19);
    case (pick)
      0: begin                                  // zero count: nothing in range
        cnt = 0;
        fdb = $urandom_range(0, 8191);
      end
      1: begin                                  // count beyond storage, window at the top
        cnt = $urandom_range(4097, 8191);
        fdb = $urandom_range(4000, 4095);
      end
      2: begin                                  // first block at or above the limit
        fdb = $urandom_range(4096, 8191);
        cnt = $urandom_range(1, 8191);
      end
      3: begin                                  // full map, reset-like
        fdb = 0;
        cnt = MAP_BLOCKS;
      end
      4: begin                                  // single block
        fdb = 0;
        cnt = 1;
      end
      5: begin                                  // empty window, first block equals count
        cnt = $urandom_range(1, MAP_BLOCKS);
        fdb = cnt;
      end
      6: begin                                  // long first-fit scan to the top
        fdb = $urandom_range(0, 3000);
        cnt = MAP_BLOCKS;
      end
      default: begin
        base = $urandom_range(0, MAP_BLOCKS - 1);
        size = $urandom_range(1, 80);
        cnt  = (base + size > MAP_BLOCKS) ? MAP_BLOCKS : base + size;
        fdb  = base + int'($urandom_range(0, size / 4));
      end
    endcase
  endtask

  initial begin
    int               sent;
    int               phase_len;
    int               alloc_bias;
    int               fdb;
    int               cnt;
    int               lim;
    int               win_lo;
    int               win_hi;
    int               target;
    int               pick;
    int               burst_left;
    action_t          act;
    logic [BLK_W-1:0] blk;

    // Scripted part: typed answers where they are obvious, shadow elsewhere.
    add_req(ACT_ALLOC, 12'd0,    1'b1, ST_OK,           12'd0);
    add_req(ACT_ALLOC, 12'd0,    1'b1, ST_OK,           12'd1);
    add_req(ACT_FREE,  12'd4095, 1'b1, ST_ALREADY_FREE, 12'd0);
    add_req(ACT_FREE,  12'd1,    1'b1, ST_OK,           12'd0);
    add_req(ACT_FREE,  12'd1,    1'b1, ST_ALREADY_FREE, 12'd0);
    add_req(ACT_ALLOC, 12'd4095, 1'b1, ST_OK,           12'd1);
    // Zero block count: no allocation, every free out of range.
    add_reg(REG_BLOCK_COUNT, 13'd0);
    add_req(ACT_ALLOC, 12'd0,    1'b1, ST_NO_FREE,      12'd0);
    add_req(ACT_FREE,  12'd0,    1'b1, ST_OUT_OF_RANGE, 12'd0);
    // Count beyond storage clamps to the map; window is the top block only.
    add_reg(REG_BLOCK_COUNT, 13'd8191);
    add_reg(REG_FIRST_DATA_BLOCK, 13'd4095);
    add_req(ACT_ALLOC, 12'd0,    1'b1, ST_OK,           12'd4095);
    add_req(ACT_ALLOC, 12'd0,    1'b1, ST_NO_FREE,      12'd0);
    add_req(ACT_FREE,  12'd4095, 1'b1, ST_OK,           12'd0);
    // Free below the first data block is allowed.
    add_req(ACT_FREE,  12'd0,    1'b1, ST_OK,           12'd0);
    // First block at or above the limit: empty scan.
    add_reg(REG_FIRST_DATA_BLOCK, 13'd8191);
    add_req(ACT_ALLOC, 12'd0,    1'b1, ST_NO_FREE,      12'd0);
    add_reg(REG_FIRST_DATA_BLOCK, 13'd4096);
    add_reg(REG_BLOCK_COUNT, 13'd4096);
    add_req(ACT_ALLOC, 12'd0,    1'b1, ST_NO_FREE,      12'd0);
    // Tiny window: fill it, overflow it, free out of range and in range.
    add_reg(REG_FIRST_DATA_BLOCK, 13'd0);
    add_reg(REG_BLOCK_COUNT, 13'd3);
    add_req(ACT_ALLOC, 12'd0,    1'b0, ST_OK,           12'd0);
    add_req(ACT_ALLOC, 12'd0,    1'b0, ST_OK,           12'd0);
    add_req(ACT_ALLOC, 12'd0,    1'b0, ST_OK,           12'd0);
    add_req(ACT_FREE,  12'd3,    1'b1, ST_OUT_OF_RANGE, 12'd0);
    add_req(ACT_FREE,  12'd4095, 1'b1, ST_OUT_OF_RANGE, 12'd0);
    add_req(ACT_FREE,  12'd2,    1'b0, ST_OK,           12'd0);
    add_reg(REG_FIRST_DATA_BLOCK, 13'd2);
    add_reg(REG_BLOCK_COUNT, 13'd1);
    add_req(ACT_ALLOC, 12'd0,    1'b1, ST_NO_FREE,      12'd0);
    add_reg(REG_FIRST_DATA_BLOCK, 13'd0);
    add_req(ACT_ALLOC, 12'd0,    1'b0, ST_OK,           12'd0);
    add_req(ACT_FREE,  12'd0,    1'b0, ST_OK,           12'd0);
    add_reg(REG_BLOCK_COUNT, 13'd4096);
    add_req(ACT_ALLOC, 12'd0,    1'b0, ST_OK,           12'd0);

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the script; write registers only once the block has gone idle.
    foreach (script[r]) begin
      if (script[r].kind == ROW_REG) begin
        wait_drained();
        write_reg(script[r].idx, script[r].data);
      end else begin
        send_request(script[r].act, script[r].blk, script[r].typed, script[r].res);
        hold_off($urandom_range(0, 2));
      end
    end

    // Random part: phases of one register setting each, all checked against the shadow.
    sent       = 0;
    burst_left = 0;
    while (sent < RANDOM_REQS) begin
      wait_drained();
      choose_window(fdb, cnt);
      if ($urandom_range(0, 1) != 0) begin
        write_reg(REG_FIRST_DATA_BLOCK, fdb[CFG_W-1:0]);
        write_reg(REG_BLOCK_COUNT, cnt[CFG_W-1:0]);
      end else begin
        write_reg(REG_BLOCK_COUNT, cnt[CFG_W-1:0]);
        write_reg(REG_FIRST_DATA_BLOCK, fdb[CFG_W-1:0]);
      end

      // Aim frees mostly at the live window, a little below it and around the limit.
      lim    = (cnt > MAP_BLOCKS) ? MAP_BLOCKS : cnt;
      win_lo = (fdb < lim) ? fdb : lim;
      win_lo = win_lo - int'($urandom_range(0, (win_lo < 8) ? win_lo : 8));
      win_hi = (lim > 0) ? lim - 1 : 0;
      if (win_lo > win_hi)
        win_lo = win_hi;
      alloc_bias = $urandom_range(25, 85);
      phase_len  = $urandom_range(20, 120);
      if (phase_len > RANDOM_REQS - sent)
        phase_len = RANDOM_REQS - sent;

      repeat (phase_len) begin
        // Sender bursts: random gaps between bursts, some long bursts with no gap at all.
        if (burst_left == 0) begin
          pick = $urandom_range(0, 9);
          hold_off((pick < 3) ? 0 : $urandom_range(1, 12));
          burst_left = (pick == 9) ? 48 : $urandom_range(1, 16);
        end
        burst_left--;

        // Pause now and then until every result is back.
        if ($urandom_range(0, 49) == 0)
          wait_drained();

        act = ($urandom_range(0, 99) < alloc_bias) ? ACT_ALLOC : ACT_FREE;
        pick = $urandom_range(0, 99);
        if (act == ACT_ALLOC || pick >= 80) begin
          target = $urandom_range(0, MAP_BLOCKS - 1);
        end else if (pick < 60) begin
          target = $urandom_range(win_lo, win_hi);
        end else begin
          target = lim + int'($urandom_range(0, 4)) - 2;
          if (target < 0)
            target = 0;
          if (target > MAP_BLOCKS - 1)
            target = MAP_BLOCKS - 1;
        end
        blk = target[BLK_W-1:0];
        send_request(act, blk, 1'b0, '0);
        sent++;
      end
    end

    // Drain, then give the block time to show any stray result.
    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bba_pkg.sv
hw/rtl/block_bitmap_allocator_top.sv
bench/block_bitmap_allocator_top_tb.sv
